>>> hw/rtl/fcbt_pkg.sv
`default_nettype none
package fcbt_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int CFG_W    = 6;

  localparam logic [CFG_W-1:0] CAP_LIMIT_RST = CFG_W'(32);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } fcbt_op_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } fcbt_state_t;

  // Probe that walks the row of cells, collecting match facts.
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
    logic             hit;
    logic [IDX_W-1:0] first;
    logic [VAL_W-1:0] last;
  } fcbt_tok_t;

  // Write broadcast to all cells; the addressed cell takes it.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] data;
  } fcbt_wr_t;

endpackage
`default_nettype wire

>>> hw/rtl/fcbt_cell.sv
`default_nettype none
module fcbt_cell
  import fcbt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire logic [CNT_W-1:0] held,
  input  wire fcbt_tok_t        tok_in,
  input  wire fcbt_wr_t         wr,
  output fcbt_tok_t             tok_out
);

  logic [VAL_W-1:0] entry_r;
  fcbt_tok_t        tok_r;
  fcbt_tok_t        tok_nxt;
  logic             live;
  logic             eq;

  always_comb begin
    live    = CNT_W'(cell_idx) < held;
    eq      = live && (tok_in.value == entry_r);
    tok_nxt = tok_in;
    if (eq) begin
      tok_nxt.count = tok_in.count + CNT_W'(1);
      tok_nxt.hit   = 1'b1;
      if (!tok_in.hit) begin
        tok_nxt.first = cell_idx;
      end
    end
    // Grab the top entry on the way past, for remove.
    if ((CNT_W'(cell_idx) + CNT_W'(1)) == held) begin
      tok_nxt.last = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      entry_r <= wr.data;
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

>>> hw/rtl/fixed_capacity_bag_table.sv
`default_nettype none
// Fixed-capacity bag of signed 32-bit values.
// Command port: an item (in_operation, in_value) is taken at a rising edge
// with start high and busy low. Operations: add, remove one match, count
// query, clear. busy stays high until the item's result is out.
// Result port: out_valid marks the result for exactly one cycle; the
// receiver cannot stall it, so it must take the result in that cycle.
// Config port: cfg_we writes cfg_data into the capacity limit (reset 32);
// write it only while the block is idle.
// Timing: each item loads a probe, walks it through the row of 32 entry
// cells, one cell per cycle, then writes back at the edge that raises the
// result strobe. A new item can be taken at the edge that ends the strobe
// cycle, so the block is through with one item before it takes the next.
// Reset empties the bag and sets the limit to 32; stored words are not
// cleared, since only slots below the count are ever read.
module fixed_capacity_bag_table
  import fcbt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_operation,
  input  wire logic signed [VAL_W-1:0] in_value,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_W-1:0]        cfg_data,
  output logic                         out_valid,
  output logic                         out_ok,
  output logic [CNT_W-1:0]             out_match_count,
  output logic                         out_found,
  output logic [CNT_W-1:0]             out_item_count,
  output logic                         out_is_empty
);

  fcbt_state_t      state_r, state_nxt;
  fcbt_op_t         op_r, op_nxt;
  fcbt_tok_t        inj_r, inj_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [CFG_W-1:0] cap_lim_r;
  logic [CFG_W-1:0] eff_lim;
  fcbt_wr_t         wr;
  fcbt_tok_t        toks [CAPACITY+1];
  fcbt_tok_t        fin;
  logic             accept;
  logic             done;

  logic             res_valid_r, res_valid_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic [CNT_W-1:0] res_mc_r, res_mc_nxt;
  logic             res_found_r, res_found_nxt;

  assign toks[0] = inj_r;
  assign fin     = toks[CAPACITY];
  assign done    = (state_r == ST_SCAN) && fin.valid;
  assign eff_lim = (cap_lim_r > CFG_W'(CAPACITY)) ? CFG_W'(CAPACITY) : cap_lim_r;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    fcbt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .held     (held_r),
      .tok_in   (toks[g]),
      .wr       (wr),
      .tok_out  (toks[g+1])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SCAN;
      ST_SCAN: if (fin.valid) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    busy          = (state_r != ST_IDLE);
    accept        = (state_r == ST_IDLE) && start;
    op_nxt        = op_r;
    inj_nxt       = '0;
    held_nxt      = held_r;
    wr            = '0;
    res_valid_nxt = 1'b0;
    res_ok_nxt    = res_ok_r;
    res_mc_nxt    = res_mc_r;
    res_found_nxt = res_found_r;

    if (accept) begin
      op_nxt        = fcbt_op_t'(in_operation);
      inj_nxt.valid = 1'b1;
      inj_nxt.value = in_value;
    end

    if (done) begin
      res_valid_nxt = 1'b1;
      res_ok_nxt    = 1'b1;
      res_mc_nxt    = '0;
      res_found_nxt = fin.hit;
      unique case (op_r)
        OP_ADD: begin
          if (CFG_W'(held_r) < eff_lim) begin
            wr.en    = 1'b1;
            wr.idx   = held_r[IDX_W-1:0];
            wr.data  = fin.value;
            held_nxt = held_r + CNT_W'(1);
          end else begin
            res_ok_nxt = 1'b0;
          end
        end
        OP_REMOVE: begin
          if (fin.hit) begin
            // Move the top entry into the hole.
            wr.en    = 1'b1;
            wr.idx   = fin.first;
            wr.data  = fin.last;
            held_nxt = held_r - CNT_W'(1);
          end else begin
            res_ok_nxt = 1'b0;
          end
        end
        OP_QUERY: res_mc_nxt = fin.count;
        OP_CLEAR: held_nxt = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inj_r       <= '0;
      held_r      <= '0;
      cap_lim_r   <= CAP_LIMIT_RST;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inj_r       <= inj_nxt;
      held_r      <= held_nxt;
      res_valid_r <= res_valid_nxt;
      if (cfg_we) begin
        cap_lim_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    res_ok_r    <= res_ok_nxt;
    res_mc_r    <= res_mc_nxt;
    res_found_r <= res_found_nxt;
  end

  assign out_valid       = res_valid_r;
  assign out_ok          = res_ok_r;
  assign out_match_count = res_mc_r;
  assign out_found       = res_found_r;
  assign out_item_count  = held_r;
  assign out_is_empty    = (held_r == '0);

endmodule
`default_nettype wire
